@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the packer rtl
// no dependencies; bodies compile away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define FFSP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define FFSP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// invariant at every edge
`define FFSP_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);
`else
`define FFSP_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define FFSP_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`define FFSP_ASSERT_ALWAYS(name, clk, rst, cond, msg)
`endif
`endif

@@ rtl/core/ffsp_pkg.sv @@
// types, codes and field layout of the first-fit sequence packer
// no dependencies; used by ffsp_ctrl, ffsp_dp and the top level
`default_nettype none

package ffsp_pkg;

  // field widths
  localparam int LEN_W      = 13;
  localparam int COL_W      = 12;
  localparam int SEG_W      = 13;
  localparam int TOTAL_W    = 12;
  localparam int ROW_OUT_W  = 6;
  localparam int KIND_W     = 2;
  localparam int ROW_CFG_W  = 7;
  localparam int COMP_CFG_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int NUM_LEN    = 4;

  // stream payload layout
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 80;
  localparam int ROW_LSB    = 0;
  localparam int COL_LSB    = 6;
  localparam int SEG_LSB    = 54;
  localparam int BATCH_LSB  = 67;

  // saturation limits
  localparam logic [SEG_W-1:0]   SEG_MAX   = 13'd8191;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 12'd4095;

  // register reset values
  localparam logic [ROW_CFG_W-1:0]  ROW_COUNT_RESET  = 7'd64;
  localparam logic [COMP_CFG_W-1:0] COMP_COUNT_RESET = 3'd1;
  localparam logic [LEN_W-1:0]      LIMIT_RESET      = 13'd4096;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMP_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_3    = 3'd5;

  // input op codes
  localparam logic OP_ELEMENT = 1'b0;
  localparam logic OP_END     = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLACED   = 2'd0,
    KIND_CLOSED   = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_ENDED    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE,
    ST_PLACE,
    ST_FLUSH,
    ST_END,
    ST_REJECT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load_in;
    logic  scan_step;
    logic  take_hit;
    logic  take_fresh;
    logic  clear_batch;
    logic  commit;
    logic  load_out;
    kind_t out_kind;
    logic  out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_long;
    logic batch_open;
    logic hit;
    logic scan_last;
    logic room;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/core/ffsp_ctrl.sv @@
// controller state machine of the first-fit sequence packer
// depends on ffsp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffsp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  ffsp_pkg::status_t status,
  output ffsp_pkg::cmd_t    cmd
);
  import ffsp_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic [2:0] pick_vec;

  assign accept   = in_valid && (state == ST_IDLE);
  assign pick_vec = {cmd.take_hit, cmd.take_fresh, cmd.scan_step};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_END) begin
            state_next = status.batch_open ? ST_FLUSH : ST_END;
          end else if (status.too_long) begin
            state_next = ST_REJECT;
          end else if (!status.batch_open) begin
            state_next = ST_PLACE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          state_next = ST_PLACE;
        end else if (status.scan_last) begin
          state_next = status.room ? ST_PLACE : ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) state_next = ST_PLACE;
      end
      ST_PLACE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_FLUSH: begin
        if (status.out_free) state_next = ST_END;
      end
      ST_END, ST_REJECT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.out_kind = KIND_PLACED;
    in_ready     = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        cmd.load_in    = accept;
        cmd.take_fresh = accept && (op == OP_ELEMENT) && !status.too_long &&
                         !status.batch_open;
      end
      ST_SCAN: begin
        cmd.take_hit   = status.hit;
        cmd.take_fresh = !status.hit && status.scan_last && status.room;
        cmd.scan_step  = !status.hit && !status.scan_last;
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_kind    = KIND_CLOSED;
          cmd.clear_batch = 1'b1;
          cmd.take_fresh  = 1'b1;
        end
      end
      ST_PLACE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_PLACED;
          cmd.out_last = 1'b1;
          cmd.commit   = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_kind    = KIND_CLOSED;
          cmd.clear_batch = 1'b1;
        end
      end
      ST_END: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_ENDED;
          cmd.out_last = 1'b1;
        end
      end
      ST_REJECT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_REJECTED;
          cmd.out_last = 1'b1;
        end
      end
      default: begin
        cmd.load_in = 1'b0;
      end
    endcase
  end

  // checks
  `FFSP_ASSERT_IMP(a_out_when_free, clk, rst, cmd.load_out, status.out_free, "result loaded into busy output")
  `FFSP_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, state != ST_IDLE, "idle right after a transfer")
  `FFSP_ASSERT_ALWAYS(a_one_pick, clk, rst, $onehot0(pick_vec), "more than one row pick at once")

endmodule

`default_nettype wire

@@ rtl/core/ffsp_dp.sv @@
// datapath of the first-fit sequence packer: config, row memory, scan, output register
// depends on ffsp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ffsp_dp #(
  parameter int MAX_ROWS       = 64,
  parameter int MAX_COMPONENTS = 4,
  parameter int MAX_SEQ        = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ffsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [ffsp_pkg::IN_DATA_W-1:0]   in_data,
  input  ffsp_pkg::cmd_t                   cmd,
  output ffsp_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ffsp_pkg::OUT_DATA_W-1:0]  out_data,
  output logic [ffsp_pkg::KIND_W-1:0]      out_kind,
  output logic                             out_last
);
  import ffsp_pkg::*;

  localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW     = $clog2(MAX_ROWS + 1);
  localparam int FWR    = $clog2(MAX_SEQ + 1);
  localparam int FW     = (FWR < LEN_W) ? FWR : LEN_W;
  localparam int WORD_W = MAX_COMPONENTS * FW + SEG_W;
  localparam int RXW    = RW + ROW_OUT_W;
  localparam int SUM_W  = LEN_W + 1;

  // configuration registers
  logic [ROW_CFG_W-1:0]  row_count;
  logic [COMP_CFG_W-1:0] component_count;
  logic [LEN_W-1:0]      seq_limit [MAX_COMPONENTS];
  logic                  cfg_clear;

  // effective settings
  logic [CW-1:0]         eff_rows;
  logic [COMP_CFG_W-1:0] eff_comps;
  logic [LEN_W-1:0]      lim_eff [MAX_COMPONENTS];
  logic                  comp_on [MAX_COMPONENTS];

  // item and scan state
  logic [LEN_W-1:0]  len_in [MAX_COMPONENTS];
  logic [LEN_W-1:0]  len_q  [MAX_COMPONENTS];
  logic              too_long;
  logic [RW-1:0]     scan_row;
  logic [RW-1:0]     scan_row_next;
  logic [CW-1:0]     scan_row_cnt;
  logic [WORD_W-1:0] row_mem [MAX_ROWS];
  logic [WORD_W-1:0] rd_word;
  logic [FW-1:0]     rd_used [MAX_COMPONENTS];
  logic              hit;

  // row chosen for placement
  logic [RW-1:0]     place_row;
  logic [CW-1:0]     place_row_cnt;
  logic [FW-1:0]     place_used [MAX_COMPONENTS];
  logic [SEG_W-1:0]  place_seg;
  logic [SEG_W-1:0]  seg_new;
  logic [WORD_W-1:0] wr_word;

  // batch counters
  logic [CW-1:0]      used_rows;
  logic [TOTAL_W-1:0] element_total;

  logic [OUT_DATA_W-1:0] out_next;
  logic [RXW-1:0]        row_ext;
  logic                  batch_clear;

  assign cfg_clear   = cfg_we && (cfg_index <= CFG_LIMIT_3);
  assign batch_clear = cfg_clear || cmd.clear_batch;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= ROW_COUNT_RESET;
      component_count <= COMP_COUNT_RESET;
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        seq_limit[c] <= LIMIT_RESET;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROW_COUNT:  row_count       <= cfg_data[ROW_CFG_W-1:0];
        CFG_COMP_COUNT: component_count <= cfg_data[COMP_CFG_W-1:0];
        default: begin
          for (int c = 0; c < MAX_COMPONENTS; c++) begin
            if (cfg_index == CFG_IDX_W'(int'(CFG_LIMIT_0) + c)) begin
              seq_limit[c] <= cfg_data[LEN_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // clamp settings to their legal ranges
  always_comb begin
    if (row_count == '0) begin
      eff_rows = CW'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      eff_rows = CW'(MAX_ROWS);
    end else begin
      eff_rows = CW'(row_count);
    end
    if (component_count == '0) begin
      eff_comps = COMP_CFG_W'(1);
    end else if (32'(component_count) > 32'(MAX_COMPONENTS)) begin
      eff_comps = COMP_CFG_W'(MAX_COMPONENTS);
    end else begin
      eff_comps = component_count;
    end
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      if (seq_limit[c] == '0) begin
        lim_eff[c] = LEN_W'(1);
      end else if (32'(seq_limit[c]) > 32'(MAX_SEQ)) begin
        lim_eff[c] = LEN_W'(MAX_SEQ);
      end else begin
        lim_eff[c] = seq_limit[c];
      end
      comp_on[c] = (COMP_CFG_W'(c) < eff_comps);
    end
  end

  // length check on the incoming item
  always_comb begin
    too_long = 1'b0;
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      len_in[c] = in_data[c*LEN_W +: LEN_W];
      if (comp_on[c] && (len_in[c] > lim_eff[c])) too_long = 1'b1;
    end
  end

  // latch lengths, unused components count as zero
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      for (int c = 0; c < MAX_COMPONENTS; c++) begin
        len_q[c] <= comp_on[c] ? len_in[c] : '0;
      end
    end
  end

  // scan pointer, memory reads the row the pointer moves to
  always_comb begin
    if (cmd.load_in) begin
      scan_row_next = '0;
    end else if (cmd.scan_step) begin
      scan_row_next = scan_row + RW'(1);
    end else begin
      scan_row_next = scan_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
    end else begin
      scan_row <= scan_row_next;
    end
  end

  // row memory: used cells per component and segment count
  always_ff @(posedge clk) begin
    if (cmd.commit) row_mem[place_row] <= wr_word;
    rd_word <= row_mem[scan_row_next];
  end

  // fit test of the scanned row
  always_comb begin
    hit = 1'b1;
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      rd_used[c] = rd_word[c*FW +: FW];
      if ((SUM_W'(rd_used[c]) + SUM_W'(len_q[c])) > SUM_W'(lim_eff[c])) hit = 1'b0;
    end
  end

  // pick the placement row
  always_ff @(posedge clk) begin
    if (cmd.take_hit) begin
      place_row <= scan_row;
      place_seg <= rd_word[MAX_COMPONENTS*FW +: SEG_W];
      for (int c = 0; c < MAX_COMPONENTS; c++) place_used[c] <= rd_used[c];
    end else if (cmd.take_fresh) begin
      place_row <= cmd.clear_batch ? '0 : RW'(used_rows);
      place_seg <= '0;
      for (int c = 0; c < MAX_COMPONENTS; c++) place_used[c] <= '0;
    end
  end

  // updated row word
  always_comb begin
    seg_new = (place_seg == SEG_MAX) ? SEG_MAX : place_seg + SEG_W'(1);
    wr_word = '0;
    for (int c = 0; c < MAX_COMPONENTS; c++) begin
      wr_word[c*FW +: FW] = FW'(SUM_W'(place_used[c]) + SUM_W'(len_q[c]));
    end
    wr_word[MAX_COMPONENTS*FW +: SEG_W] = seg_new;
  end

  assign place_row_cnt = CW'(place_row);
  assign scan_row_cnt  = CW'(scan_row);

  // open rows form a prefix, so a count replaces per-row valid bits
  always_ff @(posedge clk) begin
    if (rst || batch_clear) begin
      used_rows     <= '0;
      element_total <= '0;
    end else if (cmd.commit) begin
      if (place_row_cnt == used_rows) used_rows <= used_rows + CW'(1);
      if (element_total != TOTAL_MAX) element_total <= element_total + TOTAL_W'(1);
    end
  end

  // result payload
  always_comb begin
    out_next = '0;
    row_ext  = RXW'(place_row);
    case (cmd.out_kind)
      KIND_PLACED: begin
        out_next[ROW_LSB +: ROW_OUT_W] = row_ext[ROW_OUT_W-1:0];
        for (int c = 0; c < MAX_COMPONENTS; c++) begin
          out_next[COL_LSB + c*COL_W +: COL_W] = COL_W'(LEN_W'(place_used[c]));
        end
        out_next[SEG_LSB +: SEG_W] = seg_new;
      end
      KIND_CLOSED: begin
        out_next[BATCH_LSB +: TOTAL_W] = element_total;
      end
      default: begin
        out_next = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= out_next;
      out_kind <= cmd.out_kind;
      out_last <= cmd.out_last;
    end
  end

  // status to the controller
  always_comb begin
    status.too_long   = too_long;
    status.batch_open = (used_rows != '0);
    status.hit        = hit;
    status.scan_last  = ((scan_row_cnt + CW'(1)) == used_rows);
    status.room       = (used_rows < eff_rows);
    status.out_free   = !out_valid || out_ready;
  end

  // checks
  `FFSP_ASSERT_ALWAYS(a_rows_bounded, clk, rst, used_rows <= eff_rows, "open rows exceed row count")
  `FFSP_ASSERT_IMP(a_commit_row, clk, rst, cmd.commit, place_row_cnt <= used_rows, "placement beyond open rows")
  `FFSP_ASSERT_IMP(a_hit_open, clk, rst, cmd.take_hit, scan_row_cnt < used_rows, "hit on a row not open")

endmodule

`default_nettype wire

@@ rtl/core/first_fit_sequence_packer_top.sv @@
// first-fit sequence packer: an element on an empty batch goes from idle straight to the
// place state; otherwise the open rows are scanned in order (one row scanned per cycle),
// and it takes the first row it fits, else a new row, closing the batch first when none remain
// throughput: one item in work at a time, next input accepted after its last result loads
// synchronous reset restores default config and an empty batch; no clearing pass
// depends on ffsp_pkg, ffsp_ctrl and ffsp_dp
`default_nettype none

module first_fit_sequence_packer_top #(
  parameter int MAX_ROWS       = 64,
  parameter int MAX_COMPONENTS = 4,
  parameter int MAX_SEQ        = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // length_0, length_1, length_2, length_3, zero fill
  input  logic [ffsp_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // op
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // row, col_0, col_1, col_2, col_3, segment, batch_elements, zero fill
  output logic [ffsp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // kind
  output logic [ffsp_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_we,
  input  logic [ffsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffsp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ffsp_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  ffsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .op       (s_axis_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  ffsp_dp #(
    .MAX_ROWS       (MAX_ROWS),
    .MAX_COMPONENTS (MAX_COMPONENTS),
    .MAX_SEQ        (MAX_SEQ)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_kind  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
